@@ src/lrukv_pkg.sv @@
// ----------------------------------------------------------------------------
// lrukv_pkg
// Shared types and constants for the LRU key-value cache: field widths,
// command codes, cell operations and the sequencer states.
// ----------------------------------------------------------------------------
package lrukv_pkg;

   // payload widths
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 31;
   localparam int CMD_W   = 2;
   localparam int CAP_W   = 5;

   // live capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // command codes, code 3 is unused and ignored
   typedef enum logic [CMD_W-1:0] {
      CMD_GET   = 2'd0,
      CMD_PUT   = 2'd1,
      CMD_EVICT = 2'd2
   } cmd_type;

   // operation applied by every cell of the recency chain
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_TOUCH  = 2'd1,
      CELL_INSERT = 2'd2,
      CELL_DROP   = 2'd3
   } cell_op_type;

   // control broadcast to the cells
   typedef struct packed {
      logic        compare;
      cell_op_type op;
   } cell_ctrl_type;

   // sequencer states
   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_APPLY = 1'b1
   } state_type;

endpackage

@@ src/lrukv_req_if.sv @@
// ----------------------------------------------------------------------------
// lrukv_req_if
// Request channel: command, key and write value with valid/ready.
// ----------------------------------------------------------------------------
interface lrukv_req_if;
   logic                              valid;
   logic                              ready;
   logic [lrukv_pkg::CMD_W-1:0]       cmd;
   logic signed [lrukv_pkg::KEY_W-1:0] lookup_key;
   logic [lrukv_pkg::VALUE_W-1:0]     write_value;

   modport source (output valid, output cmd, output lookup_key, output write_value,
                   input ready);
   modport sink   (input valid, input cmd, input lookup_key, input write_value,
                   output ready);
endinterface

@@ src/lrukv_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lrukv_rsp_if
// Response channel: hit flag and read value with valid/ready.
// ----------------------------------------------------------------------------
interface lrukv_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [lrukv_pkg::VALUE_W-1:0] read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface

@@ src/lrukv_csr_if.sv @@
// ----------------------------------------------------------------------------
// lrukv_csr_if
// Configuration write channel carrying the live capacity register.
// ----------------------------------------------------------------------------
interface lrukv_csr_if;
   logic                        valid;
   logic                        ready;
   logic [lrukv_pkg::CAP_W-1:0] live_capacity;

   modport source (output valid, output live_capacity, input ready);
   modport sink   (input valid, input live_capacity, output ready);
endinterface

@@ src/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value store with least-recently-used replacement,
// built as a chain of cells ordered by recency.
// ----------------------------------------------------------------------------
// Usage:
//   req_port carries one command per transaction: get, put or evict, with a
//   key and a write value. rsp_port returns one transaction per get holding
//   the hit flag and the stored value (zero on a miss); put and evict give
//   none. csr_port writes the live capacity, always ready, and is meant to
//   be written while the block is idle.
// Timing:
//   an accepted request compares its key in every cell in the accept cycle,
//   the chain applies the move-to-front, insert or drop in the update state
//   that follows, and the response is valid the cycle after that. No new
//   request is taken until the chain update finishes, set by the registered
//   match flags between compare and chain update.
// Reset:
//   clears all valid bits and restores a live capacity of 16, no clearing
//   pass is needed.
// Stall:
//   a waiting response sits in the output register while the next request
//   is taken; a get finishing while that register is still full holds in
//   the update cycle until the receiver takes the response.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic       clock,
   input  logic       reset,
   lrukv_req_if.sink  req_port,
   lrukv_rsp_if.source rsp_port,
   lrukv_csr_if.sink  csr_port
);

   // sequencer
   lrukv_pkg::state_type state_ff, state_in;

   // request held across the update cycle
   logic [lrukv_pkg::CMD_W-1:0]        cmd_ff;
   logic signed [lrukv_pkg::KEY_W-1:0] key_ff;
   logic [lrukv_pkg::VALUE_W-1:0]      value_ff;

   // configuration
   logic [lrukv_pkg::CAP_W-1:0] live_capacity_ff;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_hit_ff;
   logic [lrukv_pkg::VALUE_W-1:0] rsp_value_ff;

   // chain signals
   logic signed [lrukv_pkg::KEY_W-1:0] key_arr   [ENTRIES];
   logic [lrukv_pkg::VALUE_W-1:0]      value_arr [ENTRIES];
   logic [ENTRIES-1:0]                 valid_vec;
   logic [ENTRIES-1:0]                 match_vec;
   logic [ENTRIES-1:0]                 keep_vec;
   logic [ENTRIES:0]                   below_chain;

   lrukv_pkg::cell_ctrl_type      cell_ctrl;
   logic                          req_accept;
   logic                          finish;
   logic                          is_get;
   logic                          any_hit;
   logic [lrukv_pkg::VALUE_W-1:0] hit_value;
   logic [lrukv_pkg::VALUE_W-1:0] front_value;

   assign req_accept = req_port.valid && req_port.ready;
   assign is_get     = (lrukv_pkg::cmd_type'(cmd_ff) == lrukv_pkg::CMD_GET);
   assign any_hit    = |match_vec;

   // value of the hit entry, at most one match
   always_comb begin
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_value = hit_value | (value_arr[i] & {lrukv_pkg::VALUE_W{match_vec[i]}});
      end
   end

   // entry that lands at the head of the chain
   assign front_value = is_get ? hit_value : value_ff;

   // a get may finish only when the response register is free
   assign finish = (state_ff == lrukv_pkg::ST_APPLY) &&
                   (!is_get || !rsp_valid_ff || rsp_port.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lrukv_pkg::ST_IDLE: begin
            if (req_accept) state_in = lrukv_pkg::ST_APPLY;
         end
         lrukv_pkg::ST_APPLY: begin
            if (finish) state_in = lrukv_pkg::ST_IDLE;
         end
         default: state_in = lrukv_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_port.ready    = 1'b0;
      cell_ctrl.compare = 1'b0;
      cell_ctrl.op      = lrukv_pkg::CELL_HOLD;
      unique case (state_ff)
         lrukv_pkg::ST_IDLE: begin
            req_port.ready    = 1'b1;
            cell_ctrl.compare = req_port.valid;
         end
         lrukv_pkg::ST_APPLY: begin
            if (finish) begin
               unique case (cmd_ff)
                  lrukv_pkg::CMD_GET: begin
                     cell_ctrl.op = any_hit ? lrukv_pkg::CELL_TOUCH : lrukv_pkg::CELL_HOLD;
                  end
                  lrukv_pkg::CMD_PUT: begin
                     cell_ctrl.op = any_hit ? lrukv_pkg::CELL_TOUCH : lrukv_pkg::CELL_INSERT;
                  end
                  lrukv_pkg::CMD_EVICT: begin
                     cell_ctrl.op = lrukv_pkg::CELL_DROP;
                  end
                  default: begin
                     cell_ctrl.op = lrukv_pkg::CELL_HOLD;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // response register next valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_port.ready) rsp_valid_in = 1'b0;
      if (finish && is_get) rsp_valid_in = 1'b1;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= lrukv_pkg::ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         live_capacity_ff <= lrukv_pkg::CAP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_port.valid && csr_port.ready) begin
            live_capacity_ff <= csr_port.live_capacity;
         end
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req_port.cmd;
         key_ff   <= req_port.lookup_key;
         value_ff <= req_port.write_value;
      end
      if (finish && is_get) begin
         rsp_hit_ff   <= any_hit;
         rsp_value_ff <= hit_value;
      end
   end

   assign csr_port.ready      = 1'b1;
   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.hit        = rsp_hit_ff;
   assign rsp_port.read_value = rsp_value_ff;

   // chain ends
   assign below_chain[ENTRIES] = 1'b0;

   // recency chain, cell 0 is the most recent entry
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic signed [lrukv_pkg::KEY_W-1:0] prev_key;
      logic [lrukv_pkg::VALUE_W-1:0]      prev_value;
      logic                               prev_valid;
      logic                               next_valid;

      // a cell survives an insert only below the effective capacity
      assign keep_vec[i] = (i == 0) || (32'(i) < 32'(live_capacity_ff));

      if (i == 0) begin : g_head
         assign prev_key   = key_ff;
         assign prev_value = front_value;
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_key   = key_arr[i-1];
         assign prev_value = value_arr[i-1];
         assign prev_valid = valid_vec[i-1];
      end

      if (i == ENTRIES - 1) begin : g_tail
         assign next_valid = 1'b0;
      end else begin : g_inner
         assign next_valid = valid_vec[i+1];
      end

      lrukv_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (cell_ctrl),
         .lookup_key    (req_port.lookup_key),
         .prev_key      (prev_key),
         .prev_value    (prev_value),
         .prev_valid    (prev_valid),
         .next_valid    (next_valid),
         .keep          (keep_vec[i]),
         .below_hit_in  (below_chain[i+1]),
         .key           (key_arr[i]),
         .value         (value_arr[i]),
         .valid         (valid_vec[i]),
         .match         (match_vec[i]),
         .below_hit_out (below_chain[i])
      );
   end

`ifndef ASSERT_OFF
   // live entries always form an unbroken run from the head of the chain
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + 1'b1)) == '0)
      else $error("valid entries not contiguous from chain head");

   // a key is held at most once
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lrukv_pkg::ST_APPLY) |-> $onehot0(match_vec))
      else $error("key matched in more than one cell");

   // an accepted request always moves to the update cycle
   a_accept_apply: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == lrukv_pkg::ST_APPLY))
      else $error("accepted request did not reach update cycle");

   // a response appears only after a get finished
   a_rsp_from_get: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(finish && is_get))
      else $error("response raised without a finished get");

   // after an insert the chain head is live and at most ENTRIES entries are live
   a_insert_cap: assert property (@(posedge clock) disable iff (reset)
      (cell_ctrl.op == lrukv_pkg::CELL_INSERT) |=>
         (valid_vec[0] && ($countones(valid_vec) <= ENTRIES)))
      else $error("insert left the chain head empty");
`endif

endmodule

@@ src/lrukv_cell.sv @@
// ----------------------------------------------------------------------------
// lrukv_cell
// One slot of the recency chain. Position in the chain is the recency rank:
// the cell takes its upper neighbor's entry on a touch or insert and its
// lower neighbor's valid bit on a drop.
// ----------------------------------------------------------------------------
module lrukv_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  lrukv_pkg::cell_ctrl_type            ctrl,
   input  logic signed [lrukv_pkg::KEY_W-1:0]  lookup_key,
   input  logic signed [lrukv_pkg::KEY_W-1:0]  prev_key,
   input  logic [lrukv_pkg::VALUE_W-1:0]       prev_value,
   input  logic                                prev_valid,
   input  logic                                next_valid,
   input  logic                                keep,
   input  logic                                below_hit_in,
   output logic signed [lrukv_pkg::KEY_W-1:0]  key,
   output logic [lrukv_pkg::VALUE_W-1:0]       value,
   output logic                                valid,
   output logic                                match,
   output logic                                below_hit_out
);

   logic signed [lrukv_pkg::KEY_W-1:0] key_ff, key_in;
   logic [lrukv_pkg::VALUE_W-1:0]      value_ff, value_in;
   logic                               valid_ff, valid_in;
   logic                               match_ff, match_in;
   logic                               shift;

   // this cell or one further down holds the hit entry
   assign below_hit_out = match_ff | below_hit_in;

   // key compare at request acceptance
   always_comb begin
      match_in = match_ff;
      if (ctrl.compare) begin
         match_in = valid_ff && (key_ff == lookup_key);
      end
   end

   // entry update for the chain operation
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      valid_in = valid_ff;
      shift    = 1'b0;
      unique case (ctrl.op)
         lrukv_pkg::CELL_HOLD: begin
         end
         lrukv_pkg::CELL_TOUCH: begin
            shift = below_hit_out;
         end
         lrukv_pkg::CELL_INSERT: begin
            shift = 1'b1;
         end
         lrukv_pkg::CELL_DROP: begin
            valid_in = next_valid;
         end
         default: begin
         end
      endcase
      if (shift) begin
         key_in   = prev_key;
         value_in = prev_value;
         valid_in = prev_valid & (keep | (ctrl.op == lrukv_pkg::CELL_TOUCH));
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key   = key_ff;
   assign value = value_ff;
   assign valid = valid_ff;
   assign match = match_ff;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lru_key_value_cache. A scoreboard class keeps its
// own recency-ordered copy of the cache, predicts the response of every
// accepted get and compares it with the response channel. Plain tasks drive
// a directed opening and then random phases at several live capacities,
// with random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module tb;

   localparam int                          NUM_SLOTS     = 16;
   localparam int                          POOL_MAX      = 32;
   localparam int                          SETTLE_CYCLES = 4;
   localparam int                          STALL_LIMIT   = 4000;
   localparam int                          EXP_DEPTH     = 8;
   localparam logic [lrukv_pkg::CMD_W-1:0] CMD_UNUSED    = 2'd3;

   // expected get response
   typedef struct packed {
      logic                          hit;
      logic [lrukv_pkg::VALUE_W-1:0] read_value;
   } read_result_type;

   // cache predictor and response checker
   class cache_scoreboard;
      logic [lrukv_pkg::KEY_W-1:0]   key_mem [NUM_SLOTS];
      logic [lrukv_pkg::VALUE_W-1:0] value_mem [NUM_SLOTS];
      bit                            slot_valid [NUM_SLOTS];
      int                            slot_rank [NUM_SLOTS];
      int                            live_count;
      logic [lrukv_pkg::CAP_W-1:0]   capacity;
      read_result_type               exp_ring [EXP_DEPTH];
      int                            exp_head, exp_tail, exp_count;
      int                            errors;
      int                            num_gets, num_hits, num_puts, num_evicts, num_unused;
      int                            num_cap_writes;

      function new();
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_rank[i]  = 0;
         end
         live_count     = 0;
         capacity       = lrukv_pkg::CAP_RESET;
         exp_head       = 0;
         exp_tail       = 0;
         exp_count      = 0;
         errors         = 0;
         num_gets       = 0;
         num_hits       = 0;
         num_puts       = 0;
         num_evicts     = 0;
         num_unused     = 0;
         num_cap_writes = 0;
      endfunction

      function void set_capacity(logic [lrukv_pkg::CAP_W-1:0] cap);
         capacity = cap;
         num_cap_writes++;
      endfunction

      function int pending();
         return exp_count;
      endfunction

      // append to the ring of expected reads
      function void store_expected(read_result_type result);
         if (exp_count == EXP_DEPTH) begin
            $display("%0t: expected read ring overflow, expected at most %0d actual %0d",
                     $time, EXP_DEPTH, exp_count + 1);
            errors++;
            return;
         end
         exp_ring[exp_tail] = result;
         exp_tail           = (exp_tail + 1) % EXP_DEPTH;
         exp_count++;
      endfunction

      // oldest expected read
      function read_result_type take_expected();
         read_result_type result;
         result   = exp_ring[exp_head];
         exp_head = (exp_head + 1) % EXP_DEPTH;
         exp_count--;
         return result;
      endfunction

      // zero acts as one, anything above the slot count saturates
      function int effective_capacity();
         if (capacity == 0) return 1;
         if (capacity > NUM_SLOTS) return NUM_SLOTS;
         return int'(capacity);
      endfunction

      function int find_slot(logic [lrukv_pkg::KEY_W-1:0] key);
         for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_valid[i] && key_mem[i] == key) return i;
         return -1;
      endfunction

      // move an entry to the front of the recency order
      function void promote(int slot);
         int r;
         r = slot_rank[slot];
         for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_valid[i] && slot_rank[i] < r) slot_rank[i]++;
         slot_rank[slot] = 0;
      endfunction

      // remove the least recent entry, no-op on an empty cache
      function void drop_oldest();
         if (live_count == 0) return;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_valid[i] && slot_rank[i] == live_count - 1) begin
               slot_valid[i] = 1'b0;
               slot_rank[i]  = 0;
               live_count--;
               return;
            end
         end
      endfunction

      // new key goes to the lowest free slot as the most recent entry
      function void insert_key(logic [lrukv_pkg::KEY_W-1:0] key,
                               logic [lrukv_pkg::VALUE_W-1:0] value);
         int slot;
         slot = -1;
         while (live_count >= effective_capacity()) drop_oldest();
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!slot_valid[i]) begin
               if (slot < 0) slot = i;
            end else begin
               slot_rank[i]++;
            end
         end
         if (slot < 0) return;
         key_mem[slot]    = key;
         value_mem[slot]  = value;
         slot_valid[slot] = 1'b1;
         slot_rank[slot]  = 0;
         live_count++;
      endfunction

      // update the model for one accepted request transaction
      function void note_request(logic [lrukv_pkg::CMD_W-1:0] cmd,
                                 logic [lrukv_pkg::KEY_W-1:0] key,
                                 logic [lrukv_pkg::VALUE_W-1:0] value);
         int              slot;
         read_result_type result;
         if (cmd == lrukv_pkg::CMD_GET) begin
            num_gets++;
            slot = find_slot(key);
            if (slot >= 0) begin
               promote(slot);
               result.hit        = 1'b1;
               result.read_value = value_mem[slot];
               num_hits++;
            end else begin
               result.hit        = 1'b0;
               result.read_value = '0;
            end
            store_expected(result);
         end else if (cmd == lrukv_pkg::CMD_PUT) begin
            num_puts++;
            slot = find_slot(key);
            if (slot >= 0) begin
               value_mem[slot] = value;
               promote(slot);
            end else begin
               insert_key(key, value);
            end
         end else if (cmd == lrukv_pkg::CMD_EVICT) begin
            num_evicts++;
            drop_oldest();
         end else begin
            num_unused++;
         end
      endfunction

      // compare one response transaction with the oldest expected read
      function void check_read(logic hit, logic [lrukv_pkg::VALUE_W-1:0] read_value);
         read_result_type exp_read;
         if (exp_count == 0) begin
            $display("%0t: unexpected response, expected none actual hit=%0b read_value=%h",
                     $time, hit, read_value);
            errors++;
            return;
         end
         exp_read = take_expected();
         if (hit !== exp_read.hit) begin
            $display("%0t: hit mismatch, expected %0b actual %0b",
                     $time, exp_read.hit, hit);
            errors++;
         end
         if (read_value !== exp_read.read_value) begin
            $display("%0t: read_value mismatch, expected %h actual %h",
                     $time, exp_read.read_value, read_value);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   sender_idling;
   bit   receiver_stalling;
   int   quiet_cycles;

   logic [lrukv_pkg::KEY_W-1:0] key_pool [POOL_MAX];

   cache_scoreboard sb;

   lrukv_req_if req_if ();
   lrukv_rsp_if rsp_if ();
   lrukv_csr_if csr_if ();

   lru_key_value_cache #(
      .ENTRIES(NUM_SLOTS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_if),
      .rsp_port(rsp_if),
      .csr_port(csr_if)
   );

   // clock generation
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // known values on every input from time zero
   initial begin
      sb                   = new();
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.cmd           = '0;
      req_if.lookup_key    = '0;
      req_if.write_value   = '0;
      rsp_if.ready         = 1'b0;
      csr_if.valid         = 1'b0;
      csr_if.live_capacity = '0;
      sender_idling        = 1'b1;
      receiver_stalling    = 1'b1;
      quiet_cycles         = 0;
   end

   // transaction monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_request(req_if.cmd, req_if.lookup_key, req_if.write_value);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_read(rsp_if.hit, rsp_if.read_value);
         if (csr_if.valid && csr_if.ready)
            sb.set_capacity(csr_if.live_capacity);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("tb failed");
            $finish;
         end
      end
   end

   // response ready with random stall bursts
   initial begin
      int n;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         n = $urandom_range(1, 11);
         if (receiver_stalling && $urandom_range(0, 2) == 0)
            rsp_if.ready = 1'b0;
         else
            rsp_if.ready = 1'b1;
         repeat (n - 1) @(negedge clock);
      end
   end

   // one request transaction, with an optional idle burst ahead of it
   task automatic send_request(logic [lrukv_pkg::CMD_W-1:0] cmd,
                               logic [lrukv_pkg::KEY_W-1:0] key,
                               logic [lrukv_pkg::VALUE_W-1:0] value);
      int n;
      if (sender_idling && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 11);
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid       = 1'b1;
      req_if.cmd         = cmd;
      req_if.lookup_key  = key;
      req_if.write_value = value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // hold off requests until every expected read has come back
   task automatic drain_reads();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // capacity write, only with the cache idle
   task automatic write_capacity(logic [lrukv_pkg::CAP_W-1:0] cap);
      drain_reads();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_if.valid         = 1'b1;
      csr_if.live_capacity = cap;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   function automatic logic [lrukv_pkg::VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return lrukv_pkg::VALUE_W'($urandom);
   endfunction

   // random traffic over a small key pool so that hits and evictions occur
   task automatic run_phase(int count, int pool_size);
      int                          r;
      logic [lrukv_pkg::CMD_W-1:0] cmd;
      logic [lrukv_pkg::KEY_W-1:0] key;
      for (int i = 0; i < pool_size; i++) begin
         case (i)
            0: key_pool[i] = 32'h0000_0000;
            1: key_pool[i] = 32'hFFFF_FFFF;
            2: key_pool[i] = 32'h8000_0000;
            3: key_pool[i] = 32'h7FFF_FFFF;
            default: begin
               // some keys differ from a neighbor in a single bit
               if ($urandom_range(0, 3) == 0)
                  key_pool[i] = key_pool[i-1] ^ (32'h1 << $urandom_range(0, 31));
               else
                  key_pool[i] = $urandom;
            end
         endcase
      end
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 45)      cmd = lrukv_pkg::CMD_GET;
         else if (r < 85) cmd = lrukv_pkg::CMD_PUT;
         else if (r < 97) cmd = lrukv_pkg::CMD_EVICT;
         else             cmd = CMD_UNUSED;
         if ($urandom_range(0, 9) == 0)
            key = $urandom;
         else
            key = key_pool[$urandom_range(0, pool_size - 1)];
         send_request(cmd, key, pick_value());
         if ($urandom_range(0, 79) == 0) drain_reads();
      end
   endtask

   // main sequence
   initial begin
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed: empty cache, extreme keys and values, update, unused code
      send_request(lrukv_pkg::CMD_GET,   32'h0000_0000, '0);
      send_request(lrukv_pkg::CMD_EVICT, 32'h0000_0000, '0);
      send_request(CMD_UNUSED,           32'hFFFF_FFFF, '1);
      send_request(lrukv_pkg::CMD_PUT,   32'h8000_0000, '0);
      send_request(lrukv_pkg::CMD_PUT,   32'h7FFF_FFFF, '1);
      send_request(lrukv_pkg::CMD_PUT,   32'hFFFF_FFFF, 31'd1);
      send_request(lrukv_pkg::CMD_GET,   32'h8000_0000, '1);
      send_request(lrukv_pkg::CMD_GET,   32'hFFFF_FFFE, '0);
      send_request(lrukv_pkg::CMD_PUT,   32'hFFFF_FFFF, 31'h5555_5555);
      send_request(lrukv_pkg::CMD_GET,   32'hFFFF_FFFF, '0);
      send_request(lrukv_pkg::CMD_PUT,   32'h0000_0000, 31'h2AAA_AAAA);

      // capacity lowered below the live count, next insert evicts down
      write_capacity(5'd2);
      send_request(lrukv_pkg::CMD_PUT,   32'h1234_5678, 31'd1);
      send_request(lrukv_pkg::CMD_GET,   32'h7FFF_FFFF, '0);
      send_request(lrukv_pkg::CMD_GET,   32'h0000_0000, '0);
      send_request(lrukv_pkg::CMD_GET,   32'h1234_5678, '0);
      send_request(lrukv_pkg::CMD_EVICT, 32'h0000_0000, '0);
      send_request(lrukv_pkg::CMD_EVICT, 32'h0000_0000, '0);
      send_request(lrukv_pkg::CMD_EVICT, 32'h0000_0000, '0);
      send_request(lrukv_pkg::CMD_GET,   32'h1234_5678, '0);

      // random phases across capacity settings
      write_capacity(5'd16);
      run_phase(150, 20);
      write_capacity(5'd1);
      run_phase(60, 3);
      write_capacity(5'd0);
      run_phase(60, 3);
      write_capacity(5'd31);
      run_phase(100, 20);
      write_capacity(lrukv_pkg::CAP_W'($urandom_range(2, 15)));
      run_phase(100, 12);

      // closing stretch without idling on either side
      write_capacity(5'd16);
      sender_idling     = 1'b0;
      receiver_stalling = 1'b0;
      run_phase(130, 24);

      drain_reads();
      repeat (SETTLE_CYCLES * 2) @(negedge clock);
      $display("covered %0d gets (%0d hits), %0d puts, %0d evicts, %0d unused codes",
               sb.num_gets, sb.num_hits, sb.num_puts, sb.num_evicts, sb.num_unused);
      $display("over %0d capacity writes, %0d errors, %0d reads outstanding",
               sb.num_cap_writes, sb.errors, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
